>>> design/jms_pkg.sv
package jms_pkg;

   localparam int OFFSET_BITS      = 24;
   localparam int FILE_LENGTH_BITS = 24;
   localparam int SEG_LENGTH_BITS  = 17;
   localparam int CSR_DATA_BITS    = 32;
   localparam int CSR_ADDR_BITS    = 3;

   localparam logic [FILE_LENGTH_BITS-1:0] FILE_LENGTH_RESET = '1;
   localparam logic [OFFSET_BITS-1:0]      POS_MAX           = '1;

   localparam logic [0:0] CSR_IDX_FILE_LENGTH = 1'b0;

   localparam logic [7:0] BYTE_ESCAPE   = 8'hFF;
   localparam logic [7:0] BYTE_STUFF    = 8'h00;
   localparam logic [7:0] CODE_RST_LOW  = 8'hD0;
   localparam logic [7:0] CODE_RST_HIGH = 8'hD7;
   localparam logic [7:0] CODE_SOS      = 8'hDA;
   localparam logic [7:0] CODE_DQT      = 8'hDB;
   localparam logic [7:0] CODE_SOF0     = 8'hC0;
   localparam logic [7:0] CODE_DHT      = 8'hC4;

   typedef enum logic [4:0] {
      PHASE_SCAN   = 5'b00001,
      PHASE_LEN_HI = 5'b00010,
      PHASE_LEN_LO = 5'b00100,
      PHASE_SKIP   = 5'b01000,
      PHASE_DONE   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0]                 marker_code;
      logic [OFFSET_BITS-1:0]     segment_offset;
      logic [SEG_LENGTH_BITS-1:0] segment_length;
      logic                       length_declared;
      logic                       scan_begins;
   } result_type;

   function automatic logic has_length(input logic [7:0] code);
      return (code == CODE_SOS) || (code == CODE_DQT) ||
             (code == CODE_SOF0) || (code == CODE_DHT);
   endfunction

endpackage

>>> design/jpeg_marker_segmenter.sv
// JPEG marker segmenter.
// The request channel carries one file byte per transfer, with file_start
// marking the first byte of a new file, which clears the parser state.
// The response channel carries one transfer per marker segment found: its
// code, the offset of the opening 0xFF, the segment length and flags for a
// declared length and for the start of scan.
// The csr port holds file_length at byte address 0; bytes at or beyond that
// position are counted but otherwise ignored. It is to be written only while
// idle, by the user; the block itself does not enforce this. One byte is
// accepted every cycle while req_stall is low. The parser state is updated
// in the transfer cycle, and its result is registered in the output buffer.
// A two-entry output buffer lets the request side keep flowing while one
// result waits on a stalled receiver; req_stall rises only when both entries
// are full, and falls once the receiver takes a result.
// Reset clears the parser state, empties the output buffer and sets
// file_length to its all-ones value.
module jpeg_marker_segmenter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_file_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_marker_code,
   output logic [jms_pkg::OFFSET_BITS-1:0]      rsp_segment_offset,
   output logic [jms_pkg::SEG_LENGTH_BITS-1:0]  rsp_segment_length,
   output logic                                 rsp_length_declared,
   output logic                                 rsp_scan_begins,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [jms_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [jms_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [jms_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   logic [jms_pkg::FILE_LENGTH_BITS-1:0] file_length_ff;
   logic                                 req_accept;
   logic                                 new_valid;
   jms_pkg::result_type                  new_result;
   logic                                 out_valid_ff, skid_valid_ff;
   jms_pkg::result_type                  out_ff, skid_ff;
   logic                                 pop;
   logic                                 csr_sel_file_length;

   assign csr_pready          = 1'b1;
   assign csr_sel_file_length = (csr_paddr[2] == jms_pkg::CSR_IDX_FILE_LENGTH);
   assign csr_prdata          = csr_sel_file_length
                                ? jms_pkg::CSR_DATA_BITS'(file_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= jms_pkg::FILE_LENGTH_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_sel_file_length) begin
         file_length_ff <= csr_pwdata[jms_pkg::FILE_LENGTH_BITS-1:0];
      end
   end

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;

   jms_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .data_byte    (req_data_byte),
      .file_start   (req_file_start),
      .file_length  (file_length_ff),
      .result_valid (new_valid),
      .result       (new_result)
   );

   assign pop = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept && new_valid) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (req_accept && new_valid) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= new_result;
         end else begin
            out_ff <= new_result;
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_marker_code     = out_ff.marker_code;
   assign rsp_segment_offset  = out_ff.segment_offset;
   assign rsp_segment_length  = out_ff.segment_length;
   assign rsp_length_declared = out_ff.length_declared;
   assign rsp_scan_begins     = out_ff.scan_begins;

endmodule

>>> design/jms_parser.sv
module jms_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [7:0]                            data_byte,
   input  logic                                  file_start,
   input  logic [jms_pkg::FILE_LENGTH_BITS-1:0]  file_length,
   output logic                                  result_valid,
   output jms_pkg::result_type                   result
);

   logic [jms_pkg::OFFSET_BITS-1:0] pos_ff, pos_in, pos_cur;
   logic                            esc_ff, esc_in, esc_cur;
   jms_pkg::phase_type              phase_ff, phase_in, phase_cur;
   logic [7:0]                      marker_ff, marker_in, marker_cur;
   logic [jms_pkg::OFFSET_BITS-1:0] offset_ff, offset_in, offset_cur;
   logic [7:0]                      len_hi_ff, len_hi_in, len_hi_cur;
   logic [15:0]                     skip_ff, skip_in, skip_cur;
   logic [15:0]                     len_word;
   logic [15:0]                     len_fixed;
   logic [jms_pkg::OFFSET_BITS:0]   pos_plus2;
   logic                            in_file;
   logic                            is_marker;

   always_comb begin
      pos_cur    = file_start ? '0 : pos_ff;
      esc_cur    = file_start ? 1'b0 : esc_ff;
      phase_cur  = file_start ? jms_pkg::PHASE_SCAN : phase_ff;
      marker_cur = file_start ? 8'd0 : marker_ff;
      offset_cur = file_start ? '0 : offset_ff;
      len_hi_cur = file_start ? 8'd0 : len_hi_ff;
      skip_cur   = file_start ? 16'd0 : skip_ff;

      pos_in    = (pos_cur < jms_pkg::POS_MAX) ? pos_cur + 1'b1 : pos_cur;
      esc_in    = esc_cur;
      phase_in  = phase_cur;
      marker_in = marker_cur;
      offset_in = offset_cur;
      len_hi_in = len_hi_cur;
      skip_in   = skip_cur;

      pos_plus2 = {1'b0, pos_cur} + 2'd2;
      in_file   = pos_cur < file_length;
      len_word  = {len_hi_cur, data_byte};
      len_fixed = (len_word < 16'd2) ? 16'd2 : len_word;
      is_marker = !((data_byte == jms_pkg::BYTE_STUFF) ||
                    (data_byte == jms_pkg::BYTE_ESCAPE) ||
                    ((data_byte >= jms_pkg::CODE_RST_LOW) &&
                     (data_byte <= jms_pkg::CODE_RST_HIGH)));

      result_valid           = 1'b0;
      result.marker_code     = data_byte;
      result.segment_offset  = offset_cur;
      result.segment_length  = jms_pkg::SEG_LENGTH_BITS'(2);
      result.length_declared = 1'b0;
      result.scan_begins     = 1'b0;

      if (in_file) begin
         unique case (phase_cur)
            jms_pkg::PHASE_SCAN: begin
               if (!esc_cur) begin
                  if (data_byte == jms_pkg::BYTE_ESCAPE) begin
                     esc_in    = 1'b1;
                     offset_in = pos_cur;
                  end
               end else begin
                  esc_in = 1'b0;
                  if (is_marker) begin
                     marker_in = data_byte;
                     if (jms_pkg::has_length(data_byte) &&
                         (pos_plus2 < {1'b0, file_length})) begin
                        phase_in = jms_pkg::PHASE_LEN_HI;
                     end else begin
                        result_valid       = 1'b1;
                        result.scan_begins = (data_byte == jms_pkg::CODE_SOS);
                        if (data_byte == jms_pkg::CODE_SOS) begin
                           phase_in = jms_pkg::PHASE_DONE;
                        end
                     end
                  end
               end
            end
            jms_pkg::PHASE_LEN_HI: begin
               len_hi_in = data_byte;
               phase_in  = jms_pkg::PHASE_LEN_LO;
            end
            jms_pkg::PHASE_LEN_LO: begin
               skip_in                = len_fixed - 16'd2;
               phase_in               = (len_fixed != 16'd2) ? jms_pkg::PHASE_SKIP
                                                             : jms_pkg::PHASE_SCAN;
               result_valid           = 1'b1;
               result.marker_code     = marker_cur;
               result.segment_length  = {1'b0, len_fixed} + 17'd2;
               result.length_declared = 1'b1;
               result.scan_begins     = (marker_cur == jms_pkg::CODE_SOS);
               if (marker_cur == jms_pkg::CODE_SOS) begin
                  phase_in = jms_pkg::PHASE_DONE;
               end
            end
            jms_pkg::PHASE_SKIP: begin
               skip_in = skip_cur - 16'd1;
               if (skip_cur == 16'd1) begin
                  phase_in = jms_pkg::PHASE_SCAN;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         esc_ff    <= 1'b0;
         phase_ff  <= jms_pkg::PHASE_SCAN;
         marker_ff <= 8'd0;
         offset_ff <= '0;
         len_hi_ff <= 8'd0;
         skip_ff   <= 16'd0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         esc_ff    <= esc_in;
         phase_ff  <= phase_in;
         marker_ff <= marker_in;
         offset_ff <= offset_in;
         len_hi_ff <= len_hi_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

>>> design/jms_checker.sv
module jms_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [7:0]                           rsp_marker_code,
   input logic [jms_pkg::OFFSET_BITS-1:0]      rsp_segment_offset,
   input logic [jms_pkg::SEG_LENGTH_BITS-1:0]  rsp_segment_length,
   input logic                                 rsp_length_declared,
   input logic                                 rsp_scan_begins
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_marker_code) &&
         $stable(rsp_segment_offset) && $stable(rsp_segment_length) &&
         $stable(rsp_length_declared) && $stable(rsp_scan_begins))
      else $error("Stalled response changed.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

   a_scan_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scan_begins |-> rsp_marker_code == jms_pkg::CODE_SOS)
      else $error("Start of scan flagged on another marker.");

   a_undeclared_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_length_declared |-> rsp_segment_length == 17'd2)
      else $error("Undeclared segment with a length other than two.");

   a_declared_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_declared |->
         rsp_segment_length >= 17'd4 && jms_pkg::has_length(rsp_marker_code))
      else $error("Declared length too short or on a marker without one.");

endmodule

bind jpeg_marker_segmenter jms_checker u_jms_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_marker_code     (rsp_marker_code),
   .rsp_segment_offset  (rsp_segment_offset),
   .rsp_segment_length  (rsp_segment_length),
   .rsp_length_declared (rsp_length_declared),
   .rsp_scan_begins     (rsp_scan_begins)
);
